@@ rtl/core/qpd_pkg.sv @@
// Shared types, character constants and helper functions for the quoted-printable decoder.
package qpd_pkg;

  // One encoded byte of the input stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] err_code;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_HEX    = 2'd1,
    ERR_UNSAFE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_EQUAL = 2'd1,
    PH_HIGH  = 2'd2
  } phase_e;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUALS     = 8'h3D;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] SAFE_LO_A     = 8'h21;
  localparam logic [7:0] SAFE_HI_A     = 8'h3A;
  localparam logic [7:0] SAFE_SINGLE   = 8'h3C;
  localparam logic [7:0] SAFE_LO_B     = 8'h3E;
  localparam logic [7:0] SAFE_HI_B     = 8'h7E;

  // Queue depth between the front and back parts.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  // Uppercase hex digit decode; lowercase is not accepted.
  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t h;
    h.ok    = 1'b0;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok    = 1'b1;
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok    = 1'b1;
      h.value = 4'(b - 8'h41 + 8'd10);
    end
    return h;
  endfunction

  function automatic logic is_safe(logic [7:0] b);
    return (b >= SAFE_LO_A && b <= SAFE_HI_A) || (b == SAFE_SINGLE) ||
           (b >= SAFE_LO_B && b <= SAFE_HI_B);
  endfunction

  function automatic logic is_fws(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

@@ rtl/core/dkim_quoted_printable_decoder.sv @@
// Top level of the DKIM quoted-printable decoder.
// The decoder takes one encoded byte per cycle and, with the output free to move, gives
// one result per cycle; a result is presented on the output once it has passed through the
// queue and the output register (the front part's decision writes it into the queue at the
// transfer edge itself, and it is then loaded into the output register once that is free).
// Each byte yields zero or one result. The two-entry queue lets input keep flowing while
// the output is stalled briefly; in_stall_o rises only once that queue is full.
// The underscore_to_space register should be written only while the decoder is idle.
module dkim_quoted_printable_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qpd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qpd_pkg::out_item_t out_data_o
);

  logic               push, pop, full, empty;
  qpd_pkg::out_item_t push_data, head;

  assign in_stall_o = full;

  qpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  qpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  qpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/core/qpd_front.sv @@
// Front part: accepts encoded bytes, tracks escape state and forms at most one result per byte.
module qpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  input  qpd_pkg::in_item_t  in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output qpd_pkg::out_item_t push_data_o
);

  logic            us_to_space_q;
  qpd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      nibble_q, nibble_d;
  logic            err_seen_q, err_seen_d;
  logic            accept;
  qpd_pkg::hex_t   hex;
  qpd_pkg::err_e   err;
  logic            have_byte;
  logic [7:0]      value;

  assign accept = in_valid_i && !full_i;
  assign hex    = qpd_pkg::hex_decode(in_data_i.in_byte);

  always_comb begin
    phase_d     = phase_q;
    nibble_d    = nibble_q;
    err_seen_d  = err_seen_q;
    push_o      = 1'b0;
    push_data_o = '0;
    err         = qpd_pkg::ERR_NONE;
    have_byte   = 1'b0;
    value       = 8'd0;
    if (accept) begin
      if (err_seen_q) begin
        // The rest of the stream is discarded; only its last byte reports.
        if (in_data_i.in_last) begin
          push_o               = 1'b1;
          push_data_o.out_last = 1'b1;
          err_seen_d           = 1'b0;
          phase_d              = qpd_pkg::PH_NONE;
          nibble_d             = 4'd0;
        end
      end else begin
        case (phase_q)
          qpd_pkg::PH_EQUAL: begin
            if (!hex.ok) begin
              err = qpd_pkg::ERR_HEX;
            end else begin
              nibble_d = hex.value;
              phase_d  = qpd_pkg::PH_HIGH;
              if (in_data_i.in_last) err = qpd_pkg::ERR_HEX;
            end
          end
          qpd_pkg::PH_HIGH: begin
            if (!hex.ok) begin
              err = qpd_pkg::ERR_HEX;
            end else begin
              value     = {nibble_q, hex.value};
              have_byte = 1'b1;
              phase_d   = qpd_pkg::PH_NONE;
            end
          end
          default: begin
            if (us_to_space_q && in_data_i.in_byte == qpd_pkg::CH_UNDERSCORE) begin
              value     = qpd_pkg::CH_SPACE;
              have_byte = 1'b1;
            end else if (in_data_i.in_byte == qpd_pkg::CH_EQUALS) begin
              phase_d = qpd_pkg::PH_EQUAL;
              if (in_data_i.in_last) err = qpd_pkg::ERR_HEX;
            end else if (qpd_pkg::is_safe(in_data_i.in_byte)) begin
              value     = in_data_i.in_byte;
              have_byte = 1'b1;
            end else if (!qpd_pkg::is_fws(in_data_i.in_byte)) begin
              err = qpd_pkg::ERR_UNSAFE;
            end
          end
        endcase

        if (err != qpd_pkg::ERR_NONE) begin
          push_o               = 1'b1;
          push_data_o.err_code = err;
          push_data_o.out_last = in_data_i.in_last;
          err_seen_d           = !in_data_i.in_last;
          phase_d              = qpd_pkg::PH_NONE;
          nibble_d             = 4'd0;
        end else begin
          if (have_byte) begin
            push_o                = 1'b1;
            push_data_o.out_byte  = value;
            push_data_o.out_valid = 1'b1;
            push_data_o.out_last  = in_data_i.in_last;
          end else if (in_data_i.in_last) begin
            push_o               = 1'b1;
            push_data_o.out_last = 1'b1;
          end
          if (in_data_i.in_last) begin
            phase_d  = qpd_pkg::PH_NONE;
            nibble_d = 4'd0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_to_space_q <= 1'b0;
      phase_q       <= qpd_pkg::PH_NONE;
      nibble_q      <= 4'd0;
      err_seen_q    <= 1'b0;
    end else begin
      if (cfg_we_i) us_to_space_q <= cfg_wdata_i;
      phase_q    <= phase_d;
      nibble_q   <= nibble_d;
      err_seen_q <= err_seen_d;
    end
  end

endmodule

@@ rtl/core/qpd_fifo.sv @@
// Short result queue between the front and back parts.
module qpd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  qpd_pkg::out_item_t push_data_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               empty_o,
  output qpd_pkg::out_item_t head_o
);

  localparam int unsigned PtrW = (qpd_pkg::QueueDepth > 1) ? $clog2(qpd_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(qpd_pkg::QueueDepth + 1);

  qpd_pkg::out_item_t mem_q [qpd_pkg::QueueDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CntW'(qpd_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (do_pop && !do_push) count_d = count_q - 1'b1;
  end

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    if (p == PtrW'(qpd_pkg::QueueDepth - 1)) return '0;
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

@@ rtl/core/qpd_back.sv @@
// Back part: output register that takes results from the queue and presents them downstream.
module qpd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  qpd_pkg::out_item_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qpd_pkg::out_item_t out_data_o
);

  logic               valid_q, valid_d;
  qpd_pkg::out_item_t data_q;

  // Load a new result whenever the register is empty or its transfer completes now.
  assign pop_o = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the quoted-printable decoder with random streams and idling.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WatchdogLimit = 300;
  localparam int unsigned DrainCycles   = 4;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PhaseItems    = 50;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic               cfg_wdata_i = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  qpd_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  qpd_pkg::out_item_t out_data_o;

  dkim_quoted_printable_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  qpd_pkg::in_item_t  encoded_q[$];
  qpd_pkg::out_item_t decoded_q[$];
  logic [7:0]         msg_bytes[$];

  // Decoder state as the checker sees it.
  qpd_pkg::phase_e qp_phase    = qpd_pkg::PH_NONE;
  logic [3:0]      qp_high     = 4'd0;
  logic            qp_err_seen = 1'b0;
  logic            qp_us_mode  = 1'b0;

  logic in_idle_on  = 1'b0;
  logic out_idle_on = 1'b0;
  int   in_gap      = 0;
  int   out_hold    = 0;
  int   quiet_cycles = 0;
  int   mismatches  = 0;

  function automatic int draw_wait(logic on);
    return on ? int'($urandom_range(0, 10)) : 0;
  endfunction

  // Bit 4 flags a valid uppercase hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c[3:0] + 4'd9)};
    return 5'b0;
  endfunction

  function automatic void end_of_stream();
    qp_phase    = qpd_pkg::PH_NONE;
    qp_high     = 4'd0;
    qp_err_seen = 1'b0;
  endfunction

  function automatic void decode_qp(qpd_pkg::in_item_t it);
    qpd_pkg::out_item_t res;
    qpd_pkg::err_e      err;
    logic               have;
    logic [7:0]         val;
    logic [7:0]         c;
    logic [4:0]         nib;
    res  = '0;
    err  = qpd_pkg::ERR_NONE;
    have = 1'b0;
    val  = 8'd0;
    c    = it.in_byte;
    nib  = hex_nibble(c);
    // Once an error has been reported, only the last byte of the stream answers.
    if (qp_err_seen) begin
      if (it.in_last) begin
        res.out_last = 1'b1;
        decoded_q.push_back(res);
        end_of_stream();
      end
      return;
    end
    case (qp_phase)
      qpd_pkg::PH_EQUAL: begin
        if (!nib[4]) err = qpd_pkg::ERR_HEX;
        else begin
          qp_high  = nib[3:0];
          qp_phase = qpd_pkg::PH_HIGH;
          if (it.in_last) err = qpd_pkg::ERR_HEX;
        end
      end
      qpd_pkg::PH_HIGH: begin
        if (!nib[4]) err = qpd_pkg::ERR_HEX;
        else begin
          val      = {qp_high, nib[3:0]};
          have     = 1'b1;
          qp_phase = qpd_pkg::PH_NONE;
        end
      end
      default: begin
        if (qp_us_mode && c == qpd_pkg::CH_UNDERSCORE) begin
          val  = qpd_pkg::CH_SPACE;
          have = 1'b1;
        end else if (c == qpd_pkg::CH_EQUALS) begin
          qp_phase = qpd_pkg::PH_EQUAL;
          if (it.in_last) err = qpd_pkg::ERR_HEX;
        end else if ((c >= qpd_pkg::SAFE_LO_A && c <= qpd_pkg::SAFE_HI_A) ||
                     c == qpd_pkg::SAFE_SINGLE ||
                     (c >= qpd_pkg::SAFE_LO_B && c <= qpd_pkg::SAFE_HI_B)) begin
          val  = c;
          have = 1'b1;
        end else if (!(c == qpd_pkg::CH_SPACE || c == qpd_pkg::CH_TAB ||
                       c == qpd_pkg::CH_CR || c == qpd_pkg::CH_LF)) begin
          err = qpd_pkg::ERR_UNSAFE;
        end
      end
    endcase
    if (err != qpd_pkg::ERR_NONE) begin
      res.err_code = err;
      res.out_last = it.in_last;
      decoded_q.push_back(res);
      if (it.in_last) end_of_stream();
      else begin
        qp_err_seen = 1'b1;
        qp_phase    = qpd_pkg::PH_NONE;
        qp_high     = 4'd0;
      end
      return;
    end
    if (have || it.in_last) begin
      res.out_byte  = val;
      res.out_valid = have;
      res.out_last  = it.in_last;
      decoded_q.push_back(res);
    end
    if (it.in_last) end_of_stream();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(qpd_pkg::out_item_t got);
    qpd_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("result with none outstanding", int'(got), 0);
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_byte !== want.out_byte)
      report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
    if (got.out_valid !== want.out_valid)
      report_mismatch("out_valid", int'(got.out_valid), int'(want.out_valid));
    if (got.err_code !== want.err_code)
      report_mismatch("err_code", int'(got.err_code), int'(want.err_code));
    if (got.out_last !== want.out_last)
      report_mismatch("out_last", int'(got.out_last), int'(want.out_last));
  endtask

  // Input driver: presents queued bytes, holding each one while it is stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_qp(in_data_i);
        in_gap = draw_wait(in_idle_on);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (encoded_q.size() != 0) begin
          in_data_i  <= encoded_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each transfer and then stalls for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        out_hold = draw_wait(out_idle_on);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Waits until every byte has gone in and every decoded result has come out.
  task automatic settle();
    while (encoded_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(logic on);
    settle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    qp_us_mode  = on;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int send_stream();
    qpd_pkg::in_item_t it;
    int                n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      it.in_byte = msg_bytes[i];
      it.in_last = (i == n - 1);
      encoded_q.push_back(it);
    end
    msg_bytes.delete();
    return n;
  endfunction

  function automatic logic [7:0] pick_hex();
    int d;
    d = $urandom_range(0, 15);
    return (d < 10) ? 8'("0" + d) : 8'("A" + d - 10);
  endfunction

  function automatic logic [7:0] pick_safe();
    logic [7:0] c;
    c = 8'($urandom_range(qpd_pkg::SAFE_LO_A, qpd_pkg::SAFE_HI_B));
    while ((c > qpd_pkg::SAFE_HI_A && c < qpd_pkg::SAFE_SINGLE) || c == qpd_pkg::CH_EQUALS)
      c = 8'($urandom_range(qpd_pkg::SAFE_LO_A, qpd_pkg::SAFE_HI_B));
    return c;
  endfunction

  function automatic void clean_tokens(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        5, 6, 9: begin
          msg_bytes.push_back(qpd_pkg::CH_EQUALS);
          msg_bytes.push_back(pick_hex());
          msg_bytes.push_back(pick_hex());
        end
        7: begin
          case ($urandom_range(0, 3))
            0: msg_bytes.push_back(qpd_pkg::CH_SPACE);
            1: msg_bytes.push_back(qpd_pkg::CH_TAB);
            2: msg_bytes.push_back(qpd_pkg::CH_CR);
            default: msg_bytes.push_back(qpd_pkg::CH_LF);
          endcase
        end
        8: msg_bytes.push_back(qpd_pkg::CH_UNDERSCORE);
        default: msg_bytes.push_back(pick_safe());
      endcase
    end
  endfunction

  // Broken streams: raw noise, a stray byte, a truncated escape or a bad digit.
  function automatic void noisy_tokens();
    int n;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 3))
      0: for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(0, 255)));
      1: begin
        clean_tokens(n);
        msg_bytes.insert($urandom_range(0, msg_bytes.size()), 8'($urandom_range(0, 255)));
        clean_tokens($urandom_range(0, 3));
      end
      2: begin
        clean_tokens(n);
        msg_bytes.push_back(qpd_pkg::CH_EQUALS);
        if ($urandom_range(0, 1)) msg_bytes.push_back(pick_hex());
      end
      default: begin
        clean_tokens(n);
        msg_bytes.push_back(qpd_pkg::CH_EQUALS);
        if ($urandom_range(0, 1)) msg_bytes.push_back(pick_hex());
        if ($urandom_range(0, 1)) msg_bytes.push_back(8'($urandom_range("a", "f")));
        else msg_bytes.push_back(8'($urandom_range(0, 255)));
        clean_tokens($urandom_range(0, 3));
      end
    endcase
  endfunction

  initial begin
    int phase_items;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    // Range edges of the safe set, all folding whitespace, and two escapes, the last ending the stream.
    msg_bytes = '{8'h21, 8'h3A, 8'h3C, 8'h3E, 8'h7E, qpd_pkg::CH_UNDERSCORE,
                  qpd_pkg::CH_SPACE, qpd_pkg::CH_TAB, qpd_pkg::CH_CR, qpd_pkg::CH_LF,
                  qpd_pkg::CH_EQUALS, "F", "F", qpd_pkg::CH_EQUALS, "0", "9"};
    void'(send_stream());
    // An unsafe byte, after which the stream is discarded up to its last byte.
    msg_bytes = '{8'h00, "A", qpd_pkg::CH_EQUALS};
    void'(send_stream());
    // Lowercase hex is rejected.
    msg_bytes = '{qpd_pkg::CH_EQUALS, "a", "x"};
    void'(send_stream());
    // Escapes cut short by the end of the stream, then a lone unsafe byte.
    msg_bytes = '{qpd_pkg::CH_EQUALS, "A"};
    void'(send_stream());
    msg_bytes = '{qpd_pkg::CH_EQUALS};
    void'(send_stream());
    msg_bytes = '{8'hFF};
    void'(send_stream());
    // A dropped byte that ends the stream still yields a result.
    msg_bytes = '{qpd_pkg::CH_SPACE};
    void'(send_stream());

    write_mode(1'b1);
    msg_bytes = '{qpd_pkg::CH_UNDERSCORE, qpd_pkg::CH_UNDERSCORE};
    void'(send_stream());

    for (int ph = 0; ph < RandomPhases; ph++) begin
      write_mode(1'(ph % 2));
      in_idle_on  = (ph != 0) && ($urandom_range(0, 3) != 0);
      out_idle_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) noisy_tokens();
        else clean_tokens($urandom_range(1, 8));
        phase_items += send_stream();
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
